/* rtl/sus_pkg.sv */
// sus_pkg: shared types and constants for the sorted unique set.
// Used by sus_cell and sorted_unique_set; depends on nothing.

package sus_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 40;   // cmd + value, padded to whole bytes
    localparam int M_DATA_W = 8;    // ok + status + count

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_DUP      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the incoming key
        logic upd_en;   // apply the shift this cycle
        logic insert;   // 1: shift right and insert, 0: shift left and remove
    } cell_ctrl_t;

endpackage

/* rtl/sus_cell.sv */
// sus_cell: one slot of the sorted row; holds a value and its compare flags.
// Depends on sus_pkg; instantiated in a chain by sorted_unique_set.

module sus_cell (
    input  logic                              aclk,
    input  sus_pkg::cell_ctrl_t               ctrl,
    input  logic                              occupied,
    input  logic signed [sus_pkg::VAL_W-1:0]  cmp_key,
    input  logic signed [sus_pkg::VAL_W-1:0]  ins_key,
    input  logic                              left_lt,
    input  logic signed [sus_pkg::VAL_W-1:0]  left_val,
    input  logic signed [sus_pkg::VAL_W-1:0]  right_val,
    output logic                              lt,
    output logic                              eq,
    output logic signed [sus_pkg::VAL_W-1:0]  val
);

    logic signed [sus_pkg::VAL_W-1:0] val_reg;
    logic signed [sus_pkg::VAL_W-1:0] val_next;
    logic                             lt_reg;
    logic                             eq_reg;

    always_comb begin
        val_next = val_reg;
        if (!lt_reg) begin
            if (ctrl.insert) begin
                // first cell not below the key takes it, the rest move right
                val_next = left_lt ? ins_key : left_val;
            end else begin
                val_next = right_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            lt_reg <= occupied && (val_reg < cmp_key);
            eq_reg <= occupied && (val_reg == cmp_key);
        end
        if (ctrl.upd_en) begin
            val_reg <= val_next;
        end
    end

    assign lt  = lt_reg;
    assign eq  = eq_reg;
    assign val = val_reg;

endmodule

/* rtl/sorted_unique_set.sv */
// sorted_unique_set: top level; a row of sus_cell slots and the request sequencer.
// Depends on sus_pkg and sus_cell.
//
//  channel | ports            | payload (low bit first)
//  --------+------------------+------------------------------------------
//  input   | s_tvalid/tready  | s_tdata: cmd[0], value[32:1], zero[39:33]
//  result  | m_tvalid/tready  | m_tdata: ok[0], status[2:1], count[7:3]
//
// Per request: the accept edge latches every cell's compare flags against the key
// in parallel; the update state then shifts the row and loads the result.
// One request is in the row at a time; a new one is taken while a result waits.
// The shift holds while the result register is still full and m_tready is low.
// aresetn (synchronous) clears the count and the control state only.

module sorted_unique_set (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sus_pkg::S_DATA_W-1:0]  s_tdata,   // cmd, value, zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sus_pkg::M_DATA_W-1:0]  m_tdata    // ok, status, count
);

    localparam int N = sus_pkg::CAPACITY;

    sus_pkg::state_t             state_reg, state_next;
    logic [sus_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        cmd_reg;
    logic signed [sus_pkg::VAL_W-1:0] key_reg;
    logic                        m_tvalid_reg;
    logic [sus_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    sus_pkg::cell_ctrl_t         ctrl;
    logic                        s_accept;
    logic                        out_free;
    logic                        found;
    logic                        full;
    logic                        do_change;
    logic                        load_result;
    sus_pkg::status_t            status;
    logic signed [sus_pkg::VAL_W-1:0] s_value;
    logic [sus_pkg::CNT_W+sus_pkg::COUNT_W-1:0] count_ext;

    logic [N-1:0]                lt_vec;
    logic [N-1:0]                eq_vec;
    logic [N-1:0]                occ_vec;
    logic signed [sus_pkg::VAL_W-1:0] val_vec [N];

    assign s_value  = s_tdata[sus_pkg::VAL_W:1];
    assign s_tready = (state_reg == sus_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign found = |eq_vec;
    assign full  = (count_reg >= sus_pkg::CNT_W'(N));

    always_comb begin
        if (cmd_reg == sus_pkg::CMD_INSERT) begin
            if (found) begin
                status = sus_pkg::ST_DUP;
            end else if (full) begin
                status = sus_pkg::ST_FULL;
            end else begin
                status = sus_pkg::ST_DONE;
            end
        end else begin
            status = found ? sus_pkg::ST_DONE : sus_pkg::ST_NOTFOUND;
        end
    end

    assign do_change = (status == sus_pkg::ST_DONE);

    always_comb begin
        state_next  = state_reg;
        load_result = 1'b0;
        case (state_reg)
            sus_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = sus_pkg::S_UPDATE;
                end
            end
            sus_pkg::S_UPDATE: begin
                if (out_free) begin
                    load_result = 1'b1;
                    state_next  = sus_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sus_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (load_result && do_change) begin
            count_next = (cmd_reg == sus_pkg::CMD_INSERT) ? count_reg + 1'b1
                                                          : count_reg - 1'b1;
        end
    end

    assign count_ext    = (sus_pkg::CNT_W + sus_pkg::COUNT_W)'(count_next);
    assign m_tdata_next = {count_ext[sus_pkg::COUNT_W-1:0], status, do_change};

    assign ctrl.cmp_en = s_accept;
    assign ctrl.upd_en = load_result && do_change;
    assign ctrl.insert = (cmd_reg == sus_pkg::CMD_INSERT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sus_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_tdata[0];
            key_reg <= s_value;
        end
        if (load_result) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic                             left_lt;
        logic signed [sus_pkg::VAL_W-1:0] left_val;
        logic signed [sus_pkg::VAL_W-1:0] right_val;

        assign occ_vec[i] = (count_reg > sus_pkg::CNT_W'(i));

        if (i == 0) begin : g_first
            assign left_lt  = 1'b1;
            assign left_val = key_reg;
        end else begin : g_mid
            assign left_lt  = lt_vec[i-1];
            assign left_val = val_vec[i-1];
        end

        if (i == N - 1) begin : g_last
            assign right_val = val_vec[i];
        end else begin : g_inner
            assign right_val = val_vec[i+1];
        end

        sus_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (occ_vec[i]),
            .cmp_key   (s_value),
            .ins_key   (key_reg),
            .left_lt   (left_lt),
            .left_val  (left_val),
            .right_val (right_val),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i]),
            .val       (val_vec[i])
        );
    end

    // never more than the capacity held
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sus_pkg::CNT_W'(N))
        else $error("member count above capacity");

    // held values are unique, so at most one slot can match the key
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sus_pkg::S_UPDATE) |-> $onehot0(eq_vec))
        else $error("more than one slot matches the key");

    // an accepted request always reaches the shift step next
    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == sus_pkg::S_UPDATE))
        else $error("accepted request did not move to update");

    // a finished request leaves a result behind
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |=> m_tvalid_reg)
        else $error("result not presented after update");

    // the count only moves on a successful change
    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !(load_result && do_change) |=> $stable(count_reg))
        else $error("count changed without a successful request");

endmodule
